/* design/ffha_pkg.sv */
`timescale 1ns / 1ps

package ffha_pkg;

   // Internal arithmetic widths
   localparam int LEN_W  = 33;   // request plus header, no wrap
   localparam int ADDR_W = 34;   // chunk start address
   localparam int END_W  = 35;   // chunk end and grown heap top
   localparam int DIV_W  = 33;   // page divider dividend
   localparam int PG_W   = 21;   // reported page counts
   localparam int HDR_W  = 7;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_IDX_W  = 2;

   localparam logic [31:0]      HEAP_BASE_RST  = 32'h0000_0000;
   localparam logic [31:0]      HEAP_LIMIT_RST = 32'h0100_0000;
   localparam logic [HDR_W-1:0] HDR_SIZE_RST   = 7'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HDR_SIZE   = 2'd2;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_MEMORY  = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_BAD_PTR    = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_SCAN,
      OP_SHU_LD,
      OP_SHU,
      OP_A_INS,
      OP_A_SET,
      OP_A_END,
      OP_DIV_GO,
      OP_A_GROW,
      OP_A_APP,
      OP_F_NX,
      OP_F_WR,
      OP_SHD_LD,
      OP_SHD,
      OP_F_REL,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic at_end;
      logic hit;
      logic split;
      logic need_shu;
      logic shu_stop;
      logic a_fail;
      logic need_grow;
      logic grow_bad;
      logic f_last;
      logic rel_ok;
      logic gap_zero;
      logic shd_stop;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

/* design/first_fit_heap_allocator.sv */
`timescale 1ns / 1ps

// First-fit heap allocator with coalescing. Requests are handled one at a time: each
// walks the address-ordered chunk table at one entry per cycle through a table memory
// with one read and one write port, then may shift entries up (split) or down (merge)
// at one entry per cycle; page counts come from a shift and a mask by the page size.
// A scan that stops at entry k leaves at most total - k entries to shift, and the
// longest path is an append that maps new pages. Another request is accepted while
// the previous result still waits in the output register. Configuration writes take
// effect at once.
module first_fit_heap_allocator #(
   parameter int MAX_CHUNKS = 64,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] request_bytes, [63:32] block_pointer
   input  logic [ffha_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] grant_address, [33:32] status, [65:34] heap_top,
   // [86:66] pages_added, [107:87] pages_released
   output logic [ffha_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata
);

   ffha_pkg::cmd_type cmd;
   ffha_pkg::sts_type sts;

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffha_dp #(
      .MAX_CHUNKS(MAX_CHUNKS),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* design/ffha_div.sv */
`timescale 1ns / 1ps

module ffha_div #(
   parameter int PAGE_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ffha_pkg::DIV_W-1:0] num,
   output logic [ffha_pkg::DIV_W-1:0] quo,
   output logic [$clog2(PAGE_BYTES+1)-1:0] rem,
   output logic                       done
);

   localparam int PW = $clog2(PAGE_BYTES + 1);
   localparam int LG = $clog2(PAGE_BYTES);

   logic [ffha_pkg::DIV_W-1:0] num_ff, num_in;
   logic                       done_ff, done_in;

   // page size is a power of two: quotient and remainder are a shift and a mask
   always_comb begin
      num_in  = start ? num : num_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
   end

   assign quo  = num_ff >> LG;
   assign rem  = PW'(num_ff[LG-1:0]);
   assign done = done_ff;

endmodule

/* design/ffha_ctrl.sv */
`timescale 1ns / 1ps

module ffha_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ffha_pkg::sts_type sts,
   output ffha_pkg::cmd_type cmd
);

   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_SCAN     = 17'h00002,
      S_SHU_LD   = 17'h00004,
      S_SHU      = 17'h00008,
      S_A_INS    = 17'h00010,
      S_A_SET    = 17'h00020,
      S_A_END    = 17'h00040,
      S_DIV_GO   = 17'h00080,
      S_DIV_WAIT = 17'h00100,
      S_A_GROW   = 17'h00200,
      S_A_APP    = 17'h00400,
      S_F_NX     = 17'h00800,
      S_F_WR     = 17'h01000,
      S_SHD_LD   = 17'h02000,
      S_SHD      = 17'h04000,
      S_F_REL    = 17'h08000,
      S_DONE     = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = ffha_pkg::OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = ffha_pkg::OP_START;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = ffha_pkg::OP_SCAN;
            if (sts.at_end) begin
               state_in = (sts.func == ffha_pkg::FUNC_ALLOC) ? S_A_END : S_DONE;
            end else if (sts.hit) begin
               if (sts.func != ffha_pkg::FUNC_ALLOC) begin
                  state_in = S_F_NX;
               end else if (sts.split) begin
                  state_in = sts.need_shu ? S_SHU_LD : S_A_INS;
               end else begin
                  state_in = S_A_SET;
               end
            end
         end
         S_SHU_LD: begin
            cmd.op   = ffha_pkg::OP_SHU_LD;
            state_in = S_SHU;
         end
         S_SHU: begin
            cmd.op = ffha_pkg::OP_SHU;
            if (sts.shu_stop) state_in = S_A_INS;
         end
         S_A_INS: begin
            cmd.op   = ffha_pkg::OP_A_INS;
            state_in = S_A_SET;
         end
         S_A_SET: begin
            cmd.op   = ffha_pkg::OP_A_SET;
            state_in = S_DONE;
         end
         S_A_END: begin
            cmd.op = ffha_pkg::OP_A_END;
            priority if (sts.a_fail) state_in = S_DONE;
            else if (sts.need_grow) state_in = S_DIV_GO;
            else state_in = S_A_APP;
         end
         S_DIV_GO: begin
            cmd.op   = ffha_pkg::OP_DIV_GO;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               state_in = (sts.func == ffha_pkg::FUNC_ALLOC) ? S_A_GROW : S_F_REL;
            end
         end
         S_A_GROW: begin
            cmd.op   = ffha_pkg::OP_A_GROW;
            state_in = sts.grow_bad ? S_DONE : S_A_APP;
         end
         S_A_APP: begin
            cmd.op   = ffha_pkg::OP_A_APP;
            state_in = S_DONE;
         end
         S_F_NX: begin
            cmd.op = ffha_pkg::OP_F_NX;
            if (sts.f_last) state_in = sts.rel_ok ? S_DIV_GO : S_DONE;
            else state_in = S_F_WR;
         end
         S_F_WR: begin
            cmd.op   = ffha_pkg::OP_F_WR;
            state_in = sts.gap_zero ? S_DONE : S_SHD_LD;
         end
         S_SHD_LD: begin
            cmd.op   = ffha_pkg::OP_SHD_LD;
            state_in = S_SHD;
         end
         S_SHD: begin
            cmd.op = ffha_pkg::OP_SHD;
            if (sts.shd_stop) state_in = S_DONE;
         end
         S_F_REL: begin
            cmd.op   = ffha_pkg::OP_F_REL;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.op   = ffha_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/ffha_dp.sv */
`timescale 1ns / 1ps

module ffha_dp #(
   parameter int MAX_CHUNKS = 64,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ffha_pkg::cmd_type                    cmd,
   output ffha_pkg::sts_type                    sts,
   input  logic                                 req_tuser,
   input  logic [ffha_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                          csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ffha_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = $clog2(MAX_CHUNKS);
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam int PW = $clog2(PAGE_BYTES + 1);
   localparam int LW = ffha_pkg::LEN_W;
   localparam int AD = ffha_pkg::ADDR_W;
   localparam int EW = ffha_pkg::END_W;
   localparam int DW = ffha_pkg::DIV_W;
   localparam int GW = ffha_pkg::PG_W;
   localparam int HW = ffha_pkg::HDR_W;

   // chunk table: used flag on top of the 32-bit length
   logic [32:0] mem [MAX_CHUNKS];
   logic [32:0] rdata_ff;
   logic        mem_we;
   logic [AW-1:0] mem_wa, rd_addr;
   logic [32:0] mem_wd;

   logic [31:0]   base_ff, base_in, limit_ff, limit_in, top_ff, top_in;
   logic [HW-1:0] hdr_ff, hdr_in;
   logic [CW-1:0] total_ff, total_in, cur_ff, cur_in, hit_idx_ff, hit_idx_in;
   logic [CW-1:0] f_idx_ff, f_idx_in;
   logic          func_ff, func_in, prev_used_ff, prev_used_in, split_ff, split_in;
   logic [LW-1:0] len_ff, len_in;
   logic [31:0]   ptr_ff, ptr_in, prev_size_ff, prev_size_in, hit_size_ff, hit_size_in;
   logic [31:0]   left_ff, left_in, msize_ff, msize_in, top_new_ff, top_new_in;
   logic [AD-1:0] addr_ff, addr_in, prev_addr_ff, prev_addr_in, hit_addr_ff, hit_addr_in;
   logic [AD-1:0] f_addr_ff, f_addr_in;
   logic [EW-1:0] end_ff, end_in;
   logic [DW-1:0] div_num_ff, div_num_in;
   logic [1:0]    gap_ff, gap_in;
   logic [GW-1:0] pages_ff, pages_in;
   logic [31:0]   res_grant_ff, res_grant_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [GW-1:0] res_added_ff, res_added_in, res_rel_ff, res_rel_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          div_start, div_done;
   logic [DW-1:0] div_quo;
   logic [PW-1:0] div_rem;

   logic [31:0]   rd_size;
   logic          rd_used;
   logic          at_end, hit_c, split_c, full_c, over_c, grow_c, r_nz, bad_c;
   logic          nx_c, pv_c, last_c, rel_ok_c;
   logic [CW-1:0] cur_p1, cur_m1, tot_m1, hit_p1, shd_wa, src_c, f_idx_c;
   logic [AD-1:0] ptr_sum, hit_grant, f_addr_c, rel_top, rel_diff;
   logic [LW-1:0] left_c;
   logic [EW-1:0] end_c, grow_diff, tn_c;
   logic [DW-1:0] pages_sum;
   logic [31:0]   s1_c, msize_c;
   logic [1:0]    gap_c;

   assign rd_size   = rdata_ff[31:0];
   assign rd_used   = rdata_ff[32];
   assign cur_p1    = cur_ff + CW'(1);
   assign cur_m1    = cur_ff - CW'(1);
   assign tot_m1    = total_ff - CW'(1);
   assign hit_p1    = hit_idx_ff + CW'(1);
   assign shd_wa    = cur_ff - CW'(gap_ff);
   assign ptr_sum   = addr_ff + AD'(hdr_ff);
   assign hit_grant = hit_addr_ff + AD'(hdr_ff);
   assign at_end    = cur_ff >= total_ff;
   assign left_c    = {1'b0, rd_size} - len_ff;
   assign hit_c     = !at_end && (func_ff ? (rd_used && ptr_sum[31:0] == ptr_ff)
                                          : (!rd_used && {1'b0, rd_size} >= len_ff));
   assign full_c    = total_ff >= CW'(MAX_CHUNKS);
   assign split_c   = (left_c > LW'(hdr_ff)) && !full_c;
   assign end_c     = EW'(addr_ff) + EW'(len_ff);
   assign over_c    = end_c > EW'(limit_ff);
   assign grow_c    = end_c > EW'(top_ff);
   assign grow_diff = end_c - EW'(top_ff);
   assign r_nz      = div_rem != '0;
   assign tn_c      = end_ff - EW'(div_rem) + (r_nz ? EW'(PAGE_BYTES) : EW'(0));
   assign bad_c     = tn_c > EW'(32'hFFFF_FFFF);
   assign pages_sum = div_quo + DW'(r_nz);

   // merge with neighbors on free: next entry is in rdata_ff
   assign nx_c     = (hit_p1 < total_ff) && !rd_used;
   assign pv_c     = (hit_idx_ff != '0) && !prev_used_ff;
   assign s1_c     = hit_size_ff + (nx_c ? rd_size : 32'd0);
   assign msize_c  = pv_c ? (prev_size_ff + s1_c) : s1_c;
   assign f_idx_c  = hit_idx_ff - CW'(pv_c);
   assign f_addr_c = pv_c ? prev_addr_ff : hit_addr_ff;
   assign gap_c    = 2'(nx_c) + 2'(pv_c);
   assign src_c    = hit_p1 + CW'(nx_c);
   assign last_c   = src_c == total_ff;
   assign rel_ok_c = AD'(top_ff) >= f_addr_c;
   assign rel_diff = AD'(top_ff) - f_addr_c;
   assign rel_top  = f_addr_ff + AD'(div_rem);

   always_comb begin
      base_in       = base_ff;
      limit_in      = limit_ff;
      hdr_in        = hdr_ff;
      top_in        = top_ff;
      total_in      = total_ff;
      cur_in        = cur_ff;
      hit_idx_in    = hit_idx_ff;
      f_idx_in      = f_idx_ff;
      func_in       = func_ff;
      prev_used_in  = prev_used_ff;
      split_in      = split_ff;
      len_in        = len_ff;
      ptr_in        = ptr_ff;
      prev_size_in  = prev_size_ff;
      hit_size_in   = hit_size_ff;
      left_in       = left_ff;
      msize_in      = msize_ff;
      top_new_in    = top_new_ff;
      addr_in       = addr_ff;
      prev_addr_in  = prev_addr_ff;
      hit_addr_in   = hit_addr_ff;
      f_addr_in     = f_addr_ff;
      end_in        = end_ff;
      div_num_in    = div_num_ff;
      gap_in        = gap_ff;
      pages_in      = pages_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      res_added_in  = res_added_ff;
      res_rel_in    = res_rel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      rd_addr       = cur_ff[AW-1:0];
      div_start     = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            ffha_pkg::CSR_HEAP_BASE: begin
               base_in = csr_wdata;
               if (total_ff == '0) top_in = csr_wdata;
            end
            ffha_pkg::CSR_HEAP_LIMIT: limit_in = csr_wdata;
            ffha_pkg::CSR_HDR_SIZE:   hdr_in   = csr_wdata[HW-1:0];
            default: ;
         endcase
      end

      unique case (cmd.op)
         ffha_pkg::OP_START: begin
            func_in       = req_tuser;
            len_in        = LW'(req_tdata[31:0]) + LW'(hdr_ff);
            ptr_in        = req_tdata[63:32];
            cur_in        = '0;
            addr_in       = AD'(base_ff);
            prev_used_in  = 1'b1;
            res_grant_in  = '0;
            res_status_in = ffha_pkg::ST_OK;
            res_added_in  = '0;
            res_rel_in    = '0;
            rd_addr       = '0;
         end
         ffha_pkg::OP_SCAN: begin
            rd_addr = cur_p1[AW-1:0];
            if (at_end) begin
               if (func_ff != ffha_pkg::FUNC_ALLOC) res_status_in = ffha_pkg::ST_BAD_PTR;
            end else if (hit_c) begin
               hit_idx_in  = cur_ff;
               hit_size_in = rd_size;
               hit_addr_in = addr_ff;
               left_in     = left_c[31:0];
               split_in    = split_c;
            end else begin
               addr_in      = addr_ff + AD'(rd_size);
               prev_used_in = rd_used;
               prev_size_in = rd_size;
               prev_addr_in = addr_ff;
               cur_in       = cur_p1;
            end
         end
         ffha_pkg::OP_SHU_LD: begin
            cur_in  = tot_m1;
            rd_addr = tot_m1[AW-1:0];
         end
         ffha_pkg::OP_SHU: begin
            mem_we  = 1'b1;
            mem_wa  = cur_p1[AW-1:0];
            mem_wd  = rdata_ff;
            rd_addr = cur_m1[AW-1:0];
            cur_in  = cur_m1;
         end
         ffha_pkg::OP_A_INS: begin
            mem_we = 1'b1;
            mem_wa = hit_p1[AW-1:0];
            mem_wd = {1'b0, left_ff};
         end
         ffha_pkg::OP_A_SET: begin
            mem_we       = 1'b1;
            mem_wa       = hit_idx_ff[AW-1:0];
            mem_wd       = {1'b1, (split_ff ? len_ff[31:0] : hit_size_ff)};
            total_in     = total_ff + CW'(split_ff);
            res_grant_in = hit_grant[31:0];
         end
         ffha_pkg::OP_A_END: begin
            priority if (full_c) begin
               res_status_in = ffha_pkg::ST_TABLE_FULL;
            end else if (over_c) begin
               res_status_in = ffha_pkg::ST_NO_MEMORY;
            end else begin
               end_in     = end_c;
               div_num_in = grow_diff[DW-1:0];
               top_new_in = top_ff;
               pages_in   = '0;
            end
         end
         ffha_pkg::OP_DIV_GO: div_start = 1'b1;
         ffha_pkg::OP_A_GROW: begin
            if (bad_c) begin
               res_status_in = ffha_pkg::ST_NO_MEMORY;
            end else begin
               top_new_in = tn_c[31:0];
               pages_in   = pages_sum[GW-1:0];
            end
         end
         ffha_pkg::OP_A_APP: begin
            mem_we       = 1'b1;
            mem_wa       = total_ff[AW-1:0];
            mem_wd       = {1'b1, len_ff[31:0]};
            total_in     = total_ff + CW'(1);
            top_in       = top_new_ff;
            res_added_in = pages_ff;
            res_grant_in = ptr_sum[31:0];
         end
         ffha_pkg::OP_F_NX: begin
            msize_in  = msize_c;
            f_idx_in  = f_idx_c;
            f_addr_in = f_addr_c;
            gap_in    = gap_c;
            cur_in    = src_c;
            if (last_c) begin
               // drop the merged chunk at the end of the table
               total_in   = f_idx_c;
               div_num_in = rel_diff[DW-1:0];
            end
         end
         ffha_pkg::OP_F_WR: begin
            mem_we = 1'b1;
            mem_wa = f_idx_ff[AW-1:0];
            mem_wd = {1'b0, msize_ff};
         end
         ffha_pkg::OP_SHD_LD: rd_addr = cur_ff[AW-1:0];
         ffha_pkg::OP_SHD: begin
            mem_we  = 1'b1;
            mem_wa  = shd_wa[AW-1:0];
            mem_wd  = rdata_ff;
            rd_addr = cur_p1[AW-1:0];
            cur_in  = cur_p1;
            if (cur_ff == tot_m1) total_in = total_ff - CW'(gap_ff);
         end
         ffha_pkg::OP_F_REL: begin
            top_in     = rel_top[31:0];
            res_rel_in = div_quo[GW-1:0];
         end
         ffha_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {4'b0, res_rel_ff, res_added_ff, top_ff, res_status_ff,
                            res_grant_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= ffha_pkg::HEAP_BASE_RST;
         limit_ff     <= ffha_pkg::HEAP_LIMIT_RST;
         hdr_ff       <= ffha_pkg::HDR_SIZE_RST;
         top_ff       <= ffha_pkg::HEAP_BASE_RST;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         hdr_ff       <= hdr_in;
         top_ff       <= top_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      hit_idx_ff    <= hit_idx_in;
      f_idx_ff      <= f_idx_in;
      func_ff       <= func_in;
      prev_used_ff  <= prev_used_in;
      split_ff      <= split_in;
      len_ff        <= len_in;
      ptr_ff        <= ptr_in;
      prev_size_ff  <= prev_size_in;
      hit_size_ff   <= hit_size_in;
      left_ff       <= left_in;
      msize_ff      <= msize_in;
      top_new_ff    <= top_new_in;
      addr_ff       <= addr_in;
      prev_addr_ff  <= prev_addr_in;
      hit_addr_ff   <= hit_addr_in;
      f_addr_ff     <= f_addr_in;
      end_ff        <= end_in;
      div_num_ff    <= div_num_in;
      gap_ff        <= gap_in;
      pages_ff      <= pages_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      res_added_ff  <= res_added_in;
      res_rel_ff    <= res_rel_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[rd_addr];
   end

   ffha_div #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num_ff),
      .quo   (div_quo),
      .rem   (div_rem),
      .done  (div_done)
   );

   always_comb begin
      sts.func      = func_ff;
      sts.at_end    = at_end;
      sts.hit       = hit_c;
      sts.split     = split_c;
      sts.need_shu  = cur_p1 < total_ff;
      sts.shu_stop  = cur_ff == hit_p1;
      sts.a_fail    = full_c || over_c;
      sts.need_grow = grow_c;
      sts.grow_bad  = bad_c;
      sts.f_last    = last_c;
      sts.rel_ok    = rel_ok_c;
      sts.gap_zero  = gap_ff == 2'd0;
      sts.shd_stop  = cur_ff == tot_m1;
      sts.div_done  = div_done;
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
